[rtl/dipc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package dipc_pkg;

  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int NODE_W    = IDX_W + 1;
  localparam int CNT_W     = 30;
  localparam logic [CNT_W-1:0] PATH_MOD = 30'd1000000007;

  localparam logic [1:0] REQ_EDGE_A = 2'd0;
  localparam logic [1:0] REQ_EDGE_B = 2'd1;
  localparam logic [1:0] REQ_COUNT  = 2'd2;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic             graph;
    logic             clear;
    logic [IDX_W-1:0] addr;
  } es_req_t;

endpackage
`default_nettype wire

[rtl/dipc_mod_add.sv]
`timescale 1ns / 1ps
`default_nettype none
module dipc_mod_add
  import dipc_pkg::*;
(
  input  wire logic [CNT_W-1:0] a_i,
  input  wire logic [CNT_W-1:0] b_i,
  output logic      [CNT_W-1:0] sum_o
);

  logic [CNT_W:0] raw;
  logic [CNT_W:0] red;

  assign raw   = {1'b0, a_i} + {1'b0, b_i};
  assign red   = raw - {1'b0, PATH_MOD};
  assign sum_o = (raw >= {1'b0, PATH_MOD}) ? red[CNT_W-1:0] : raw[CNT_W-1:0];

endmodule
`default_nettype wire

[rtl/dipc_edge_store.sv]
`timescale 1ns / 1ps
`default_nettype none
module dipc_edge_store
  import dipc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire es_req_t              req_i,
  input  wire logic [MAX_NODES-1:0] wdata_i,
  output logic      [MAX_NODES-1:0] rdata_a_o,
  output logic      [MAX_NODES-1:0] rdata_b_o
);

  logic [MAX_NODES-1:0] mem_a [MAX_NODES];
  logic [MAX_NODES-1:0] mem_b [MAX_NODES];
  logic [MAX_NODES-1:0] vld_a_q;
  logic [MAX_NODES-1:0] vld_b_q;
  logic [MAX_NODES-1:0] rd_a_q;
  logic [MAX_NODES-1:0] rd_b_q;
  logic                 rv_a_q;
  logic                 rv_b_q;

  // row valid bits stand in for clearing the rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= '0;
      vld_b_q <= '0;
    end else if (req_i.clear) begin
      vld_a_q <= '0;
      vld_b_q <= '0;
    end else if (req_i.wr) begin
      if (req_i.graph) begin
        vld_b_q[req_i.addr] <= 1'b1;
      end else begin
        vld_a_q[req_i.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr && !req_i.graph) begin
      mem_a[req_i.addr] <= wdata_i;
    end
    if (req_i.wr && req_i.graph) begin
      mem_b[req_i.addr] <= wdata_i;
    end
    if (req_i.rd) begin
      rd_a_q <= mem_a[req_i.addr];
      rd_b_q <= mem_b[req_i.addr];
      rv_a_q <= vld_a_q[req_i.addr];
      rv_b_q <= vld_b_q[req_i.addr];
    end
  end

  assign rdata_a_o = rv_a_q ? rd_a_q : '0;
  assign rdata_b_o = rv_b_q ? rd_b_q : '0;

endmodule
`default_nettype wire

[rtl/dag_intersection_path_counter.sv]
`timescale 1ns / 1ps
`default_nettype none
// Counts paths from node 1 to node node_count over the edges loaded into both
// graphs, modulo 1000000007, in Kahn order. An edge load is one read-modify-
// write of a 64-bit adjacency row. A count request walks each adjacency row
// one column at a time through the degree and path-total memories and the one
// modular adder, for every node in use and then for each node reached in
// topological order, and it waits for the previous result to leave the output.
// The block takes no word while it works. Both edge stores are empty after
// reset and after each count; a count of a single node gives 1.
module dag_intersection_path_counter
  import dipc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [15:0] s_tdata_i,  // source_node[6:0], target_node[13:7]
  input  wire logic [1:0]  s_tuser_i,  // req_type[1:0]
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic      [31:0] m_tdata_o,  // path_count[29:0]
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LD_RD = 5'd1;
  localparam logic [4:0] S_LD_WR = 5'd2;
  localparam logic [4:0] S_CLR   = 5'd3;
  localparam logic [4:0] S_CM_RD = 5'd4;
  localparam logic [4:0] S_CM_WR = 5'd5;
  localparam logic [4:0] S_IN_RD = 5'd6;
  localparam logic [4:0] S_IN_WR = 5'd7;
  localparam logic [4:0] S_SD_RD = 5'd8;
  localparam logic [4:0] S_SD_WR = 5'd9;
  localparam logic [4:0] S_PQ    = 5'd10;
  localparam logic [4:0] S_PV_RD = 5'd11;
  localparam logic [4:0] S_PV_LD = 5'd12;
  localparam logic [4:0] S_RX_RD = 5'd13;
  localparam logic [4:0] S_RX_WR = 5'd14;
  localparam logic [4:0] S_FN_RD = 5'd15;
  localparam logic [4:0] S_FN_WR = 5'd16;

  logic [4:0]           state_q, state_d;
  logic [NODE_W-1:0]    cfg_q;
  logic [NODE_W-1:0]    eff_n;
  logic [NODE_W-1:0]    last_n;
  logic [NODE_W-1:0]    i_q, i_d;
  logic [NODE_W-1:0]    j_q, j_d;
  logic [NODE_W-1:0]    head_q, head_d;
  logic [NODE_W-1:0]    tail_q, tail_d;
  logic                 ld_graph_q, ld_graph_d;
  logic [IDX_W-1:0]     ld_row_q, ld_row_d;
  logic [IDX_W-1:0]     ld_col_q, ld_col_d;
  logic [MAX_NODES-1:0] row_q, row_d;
  logic [CNT_W-1:0]     rv_q, rv_d;
  logic                 out_vld_q, out_vld_d;
  logic [CNT_W-1:0]     out_q, out_d;

  es_req_t              es_req;
  logic [MAX_NODES-1:0] es_wdata;
  logic [MAX_NODES-1:0] es_rd_a;
  logic [MAX_NODES-1:0] es_rd_b;
  logic [MAX_NODES-1:0] common_row;

  logic [MAX_NODES-1:0] cm_mem [MAX_NODES];
  logic [NODE_W-1:0]    dg_mem [MAX_NODES];
  logic [CNT_W-1:0]     rt_mem [MAX_NODES];
  logic [IDX_W-1:0]     qu_mem [MAX_NODES];

  logic                 cm_we, cm_re;
  logic [IDX_W-1:0]     cm_waddr, cm_raddr;
  logic [MAX_NODES-1:0] cm_rdata_q;
  logic                 dg_we, dg_re;
  logic [IDX_W-1:0]     dg_waddr, dg_raddr;
  logic [NODE_W-1:0]    dg_wdata, dg_rdata_q;
  logic                 rt_we, rt_re;
  logic [IDX_W-1:0]     rt_waddr, rt_raddr;
  logic [CNT_W-1:0]     rt_wdata, rt_rdata_q;
  logic                 qu_we, qu_re;
  logic [IDX_W-1:0]     qu_waddr, qu_raddr;
  logic [IDX_W-1:0]     qu_rdata_q;
  logic [CNT_W-1:0]     madd_sum;

  logic [NODE_W-1:0]    src, dst;
  logic                 src_ok, dst_ok;

  assign src    = s_tdata_i[NODE_W-1:0];
  assign dst    = s_tdata_i[2*NODE_W-1:NODE_W];
  assign src_ok = (src != '0) && (src <= NODE_W'(MAX_NODES));
  assign dst_ok = (dst != '0) && (dst <= NODE_W'(MAX_NODES));

  assign eff_n  = (cfg_q == '0) ? NODE_W'(1) :
                  (cfg_q > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : cfg_q;
  assign last_n = eff_n - NODE_W'(1);

  assign common_row = es_rd_a & es_rd_b;

  dipc_edge_store u_edges (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (es_req),
    .wdata_i   (es_wdata),
    .rdata_a_o (es_rd_a),
    .rdata_b_o (es_rd_b)
  );

  dipc_mod_add u_madd (
    .a_i   (rt_rdata_q),
    .b_i   (rv_q),
    .sum_o (madd_sum)
  );

  always_ff @(posedge clk_i) begin
    if (cm_we) begin
      cm_mem[cm_waddr] <= common_row;
    end
    if (cm_re) begin
      cm_rdata_q <= cm_mem[cm_raddr];
    end
    if (dg_we) begin
      dg_mem[dg_waddr] <= dg_wdata;
    end
    if (dg_re) begin
      dg_rdata_q <= dg_mem[dg_raddr];
    end
    if (rt_we) begin
      rt_mem[rt_waddr] <= rt_wdata;
    end
    if (rt_re) begin
      rt_rdata_q <= rt_mem[rt_raddr];
    end
    if (qu_we) begin
      qu_mem[qu_waddr] <= j_q[IDX_W-1:0] | i_q[IDX_W-1:0];
    end
    if (qu_re) begin
      qu_rdata_q <= qu_mem[qu_raddr];
    end
  end

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    head_d     = head_q;
    tail_d     = tail_q;
    ld_graph_d = ld_graph_q;
    ld_row_d   = ld_row_q;
    ld_col_d   = ld_col_q;
    row_d      = row_q;
    rv_d       = rv_q;
    out_vld_d  = out_vld_q && !m_tready_i;
    out_d      = out_q;
    es_req     = '0;
    es_wdata   = '0;
    cm_we      = 1'b0;
    cm_re      = 1'b0;
    cm_waddr   = i_q[IDX_W-1:0];
    cm_raddr   = qu_rdata_q;
    dg_we      = 1'b0;
    dg_re      = 1'b0;
    dg_waddr   = j_q[IDX_W-1:0];
    dg_raddr   = j_q[IDX_W-1:0];
    dg_wdata   = '0;
    rt_we      = 1'b0;
    rt_re      = 1'b0;
    rt_waddr   = j_q[IDX_W-1:0];
    rt_raddr   = j_q[IDX_W-1:0];
    rt_wdata   = '0;
    qu_we      = 1'b0;
    qu_re      = 1'b0;
    qu_waddr   = tail_q[IDX_W-1:0];
    qu_raddr   = head_q[IDX_W-1:0];
    s_tready_o = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          ld_graph_d = (s_tuser_i == REQ_EDGE_B);
          ld_row_d   = IDX_W'(src - NODE_W'(1));
          ld_col_d   = IDX_W'(dst - NODE_W'(1));
          case (s_tuser_i)
            REQ_EDGE_A, REQ_EDGE_B: begin
              if (src_ok && dst_ok) begin
                state_d = S_LD_RD;
              end
            end
            REQ_COUNT: begin
              j_d     = '0;
              state_d = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_LD_RD: begin
        es_req.rd   = 1'b1;
        es_req.addr = ld_row_q;
        state_d     = S_LD_WR;
      end
      S_LD_WR: begin
        es_req.wr    = 1'b1;
        es_req.graph = ld_graph_q;
        es_req.addr  = ld_row_q;
        es_wdata     = (ld_graph_q ? es_rd_b : es_rd_a) | (MAX_NODES'(1) << ld_col_q);
        state_d      = S_IDLE;
      end
      S_CLR: begin
        dg_we    = 1'b1;
        rt_we    = 1'b1;
        rt_wdata = (j_q == '0) ? CNT_W'(1) : '0;
        j_d      = j_q + NODE_W'(1);
        if (j_q == last_n) begin
          i_d     = '0;
          state_d = S_CM_RD;
        end
      end
      S_CM_RD: begin
        es_req.rd   = 1'b1;
        es_req.addr = i_q[IDX_W-1:0];
        state_d     = S_CM_WR;
      end
      S_CM_WR: begin
        cm_we   = 1'b1;
        row_d   = common_row;
        j_d     = '0;
        state_d = S_IN_RD;
      end
      S_IN_RD: begin
        dg_re   = 1'b1;
        state_d = S_IN_WR;
      end
      S_IN_WR: begin
        dg_we    = row_q[j_q[IDX_W-1:0]];
        dg_wdata = dg_rdata_q + NODE_W'(1);
        j_d      = j_q + NODE_W'(1);
        state_d  = S_IN_RD;
        if (j_q == last_n) begin
          if (i_q == last_n) begin
            i_d     = '0;
            j_d     = '0;
            tail_d  = '0;
            state_d = S_SD_RD;
          end else begin
            i_d     = i_q + NODE_W'(1);
            state_d = S_CM_RD;
          end
        end
      end
      S_SD_RD: begin
        dg_re    = 1'b1;
        dg_raddr = i_q[IDX_W-1:0];
        state_d  = S_SD_WR;
      end
      S_SD_WR: begin
        // j_q is zero here, so the queue takes i
        if (dg_rdata_q == '0) begin
          qu_we  = 1'b1;
          tail_d = tail_q + NODE_W'(1);
        end
        i_d     = i_q + NODE_W'(1);
        state_d = S_SD_RD;
        if (i_q == last_n) begin
          i_d     = '0;
          head_d  = '0;
          state_d = S_PQ;
        end
      end
      S_PQ: begin
        if (head_q == tail_q) begin
          state_d = S_FN_RD;
        end else begin
          qu_re   = 1'b1;
          head_d  = head_q + NODE_W'(1);
          state_d = S_PV_RD;
        end
      end
      S_PV_RD: begin
        cm_re    = 1'b1;
        rt_re    = 1'b1;
        rt_raddr = qu_rdata_q;
        state_d  = S_PV_LD;
      end
      S_PV_LD: begin
        row_d   = cm_rdata_q;
        rv_d    = rt_rdata_q;
        j_d     = '0;
        state_d = S_RX_RD;
      end
      S_RX_RD: begin
        dg_re   = 1'b1;
        rt_re   = 1'b1;
        state_d = S_RX_WR;
      end
      S_RX_WR: begin
        if (row_q[j_q[IDX_W-1:0]]) begin
          rt_we    = 1'b1;
          rt_wdata = madd_sum;
          if (dg_rdata_q != '0) begin
            dg_we    = 1'b1;
            dg_wdata = dg_rdata_q - NODE_W'(1);
            if (dg_rdata_q == NODE_W'(1)) begin
              qu_we  = 1'b1;
              tail_d = tail_q + NODE_W'(1);
            end
          end
        end
        j_d     = j_q + NODE_W'(1);
        state_d = S_RX_RD;
        if (j_q == last_n) begin
          j_d     = '0;
          state_d = S_PQ;
        end
      end
      S_FN_RD: begin
        rt_re    = 1'b1;
        rt_raddr = last_n[IDX_W-1:0];
        state_d  = S_FN_WR;
      end
      S_FN_WR: begin
        if (!out_vld_d) begin
          out_vld_d    = 1'b1;
          out_d        = rt_rdata_q;
          es_req.clear = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cfg_q     <= NODE_W'(MAX_NODES);
      i_q       <= '0;
      j_q       <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      j_q       <= j_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ld_graph_q <= ld_graph_d;
    ld_row_q   <= ld_row_d;
    ld_col_q   <= ld_col_d;
    row_q      <= row_d;
    rv_q       <= rv_d;
    out_q      <= out_d;
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {2'b00, out_q};

endmodule
`default_nettype wire

[dv/dag_intersection_path_counter_tb.sv]
`timescale 1ns / 1ps
module dag_intersection_path_counter_tb;
  import dipc_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int LIMIT = 3000000;

  class path_scoreboard;
    logic [MAX_NODES-1:0] rows_a [MAX_NODES];
    logic [MAX_NODES-1:0] rows_b [MAX_NODES];
    logic [6:0] node_count;
    logic [CNT_W-1:0] counts_due[$];
    int errors;

    function void clear_graphs();
      for (int i = 0; i < MAX_NODES; i++) begin
        rows_a[i] = '0;
        rows_b[i] = '0;
      end
    endfunction

    function logic [CNT_W-1:0] count_common_paths();
      int n, head, tail;
      int in_deg [MAX_NODES];
      longint total [MAX_NODES];
      int order [MAX_NODES];
      logic [MAX_NODES-1:0] common [MAX_NODES];
      n = node_count;
      if (n < 1) n = 1;
      if (n > MAX_NODES) n = MAX_NODES;
      for (int i = 0; i < MAX_NODES; i++) begin
        common[i] = rows_a[i] & rows_b[i];
        in_deg[i] = 0;
        total[i] = 0;
      end
      total[0] = 1;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          if (common[i][j]) in_deg[j]++;
      head = 0;
      tail = 0;
      for (int i = 0; i < n; i++)
        if (in_deg[i] == 0) order[tail++] = i;
      while (head < tail) begin
        int v;
        v = order[head++];
        for (int j = 0; j < n; j++) begin
          if (common[v][j]) begin
            total[j] = (total[j] + total[v]) % 64'd1000000007;
            if (in_deg[j] > 0) begin
              in_deg[j]--;
              if (in_deg[j] == 0 && tail < MAX_NODES) order[tail++] = j;
            end
          end
        end
      end
      return total[n-1][CNT_W-1:0];
    endfunction

    function void note_word(logic [1:0] kind, logic [6:0] src, logic [6:0] dst);
      if (kind == REQ_EDGE_A || kind == REQ_EDGE_B) begin
        if (src >= 1 && src <= MAX_NODES && dst >= 1 && dst <= MAX_NODES) begin
          if (kind == REQ_EDGE_A) rows_a[src-1][dst-1] = 1'b1;
          else rows_b[src-1][dst-1] = 1'b1;
        end
      end else if (kind == REQ_COUNT) begin
        counts_due = {counts_due, count_common_paths()};
        clear_graphs();
      end
    endfunction

    function void check_word(logic [31:0] data);
      logic [CNT_W-1:0] want;
      if (counts_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0d", $time, data);
        errors++;
      end else begin
        want = counts_due.pop_front();
        if (data !== {2'b00, want}) begin
          $display("%0t: path_count mismatch, expected %0d, actual %0d", $time, want, data);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid_i = 1'b0;
  logic s_tready_o;
  logic [15:0] s_tdata_i = '0;
  logic [1:0] s_tuser_i = '0;
  logic m_tvalid_o;
  logic m_tready_i = 1'b0;
  logic [31:0] m_tdata_o;
  logic cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = '0;

  path_scoreboard sb;
  int idle_pct = 35;
  bit hold_sink = 1'b0;
  longint cycles = 0;

  dag_intersection_path_counter dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) sb.check_word(m_tdata_o);
    if (hold_sink) m_tready_i <= 1'b0;
    else m_tready_i <= ($urandom_range(99) >= idle_pct);
  end

  task automatic send_word(logic [1:0] kind, logic [6:0] src, logic [6:0] dst);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i <= kind;
    s_tdata_i <= {2'b00, dst, src};
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_word(kind, src, dst);
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (sb.counts_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_node_count(logic [6:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.node_count = value;
  endtask

  function automatic logic [6:0] pick_node(int n);
    int r;
    r = $urandom_range(99);
    if (r < 3) return 7'd0;
    if (r < 6) return 7'($urandom_range(127));
    return 7'($urandom_range((n < 1) ? 1 : (n > MAX_NODES ? MAX_NODES : n), 1));
  endfunction

  // random graph, mostly forward edges loaded into both graphs
  task automatic random_set(int n, int edges);
    logic [6:0] s, d;
    for (int e = 0; e < edges; e++) begin
      s = pick_node(n);
      d = pick_node(n);
      if ($urandom_range(9) < 8 && s > d) begin
        logic [6:0] t;
        t = s; s = d; d = t;
      end
      case ($urandom_range(9))
        0: send_word(REQ_EDGE_A, s, d);
        1: send_word(REQ_EDGE_B, s, d);
        2: send_word(REQ_NONE, 7'($urandom), 7'($urandom));
        default: begin
          send_word(REQ_EDGE_A, s, d);
          send_word(REQ_EDGE_B, s, d);
        end
      endcase
    end
    send_word(REQ_COUNT, 7'($urandom), 7'($urandom));
  endtask

  initial begin
    int n;
    sb = new();
    sb.node_count = 7'd64;
    sb.clear_graphs();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty count at reset size, single node, cycle, diamond, extremes
    send_word(REQ_COUNT, 7'd0, 7'd0);
    set_node_count(7'd1);
    send_word(REQ_COUNT, 7'd127, 7'd127);
    set_node_count(7'd0);
    send_word(REQ_EDGE_A, 7'd1, 7'd1);
    send_word(REQ_EDGE_B, 7'd1, 7'd1);
    send_word(REQ_COUNT, 7'd0, 7'd0);
    set_node_count(7'd4);
    send_word(REQ_EDGE_A, 7'd1, 7'd2);
    send_word(REQ_EDGE_B, 7'd1, 7'd2);
    send_word(REQ_EDGE_A, 7'd1, 7'd3);
    send_word(REQ_EDGE_B, 7'd1, 7'd3);
    send_word(REQ_EDGE_A, 7'd2, 7'd4);
    send_word(REQ_EDGE_B, 7'd2, 7'd4);
    send_word(REQ_EDGE_A, 7'd3, 7'd4);
    send_word(REQ_EDGE_B, 7'd3, 7'd4);
    send_word(REQ_EDGE_A, 7'd3, 7'd4);
    send_word(REQ_EDGE_B, 7'd4, 7'd2);
    send_word(REQ_EDGE_A, 7'd0, 7'd4);
    send_word(REQ_EDGE_B, 7'd65, 7'd127);
    send_word(REQ_NONE, 7'd1, 7'd4);
    send_word(REQ_COUNT, 7'd0, 7'd0);
    set_node_count(7'd127);
    send_word(REQ_EDGE_A, 7'd1, 7'd64);
    send_word(REQ_EDGE_B, 7'd1, 7'd64);
    send_word(REQ_COUNT, 7'd0, 7'd0);
    set_node_count(7'd64);
    send_word(REQ_EDGE_A, 7'd64, 7'd1);
    send_word(REQ_EDGE_B, 7'd64, 7'd1);
    send_word(REQ_COUNT, 7'd0, 7'd0);

    // dense forward graph on 64 nodes so counts wrap the modulus
    for (int i = 1; i < 64; i++)
      for (int j = i + 1; j <= 64 && j <= i + 2; j++) begin
        send_word(REQ_EDGE_A, 7'(i), 7'(j));
        send_word(REQ_EDGE_B, 7'(i), 7'(j));
      end
    send_word(REQ_COUNT, 7'd0, 7'd0);

    // sink holds off while counts queue up behind it
    set_node_count(7'd3);
    hold_sink = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      for (int k = 0; k < 6; k++) random_set(3, 3);
    join

    for (int phase = 0; phase < 8; phase++) begin
      n = (phase == 7) ? 64 : $urandom_range(12, 1);
      set_node_count(7'(n));
      idle_pct = (phase == 3) ? 0 : 35;
      for (int k = 0; k < 3; k++) random_set(n, $urandom_range(10));
    end
    idle_pct = 35;

    drain();
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
